/* hw/rtl/sevq_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the sorted event queue.
// Used by sevq_ctrl, sevq_datapath and the sorted_event_queue top level.
package sevq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH  = 64;
    localparam int DEFAULT_KEY_BITS     = 32;
    localparam int DEFAULT_PAYLOAD_BITS = 32;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } opcode_t;

    // Read address select: one below or two below the current slot index.
    typedef enum logic {
        RD_IDX_M1 = 1'b0,
        RD_IDX_M2 = 1'b1
    } rd_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_POP_WAIT,
        S_INS_WAIT,
        S_PLACE,
        S_RESP_POP,
        S_RESP_INS,
        S_RESP_EMPTY,
        S_RESP_FULL
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    shift;
        logic    place;
        logic    pop;
        logic    load_out;
        status_t out_status;
        logic    out_popped;
    } cmd_t;

    typedef struct packed {
        logic is_pop;
        logic empty;
        logic full;
        logic idx_zero;
        logic idx_one;
        logic prev_less;
        logic out_busy;
    } stat_t;

endpackage

/* hw/rtl/sorted_event_queue.sv */
`timescale 1ns / 1ps
// Sorted event queue: a bounded min-key queue of (key, payload) entries.
// Input channel (in_valid/in_ready) carries opcode, key_time, entry_payload;
// opcode insert stores an entry, opcode pop removes the smallest-key entry.
// Among equal keys the most recently inserted entry is popped first.
// Output channel (out_valid/out_ready) gives one transaction per input:
// status (ok, pop from empty, insert into full), the popped key and payload
// (zero unless popped_valid), and the occupancy after the operation.
// One operation is in flight at a time. An insert moves each stored entry
// whose key is smaller than the new key up one memory slot per cycle through
// the single read and write port before the new entry is placed; in_ready
// rises again together with out_valid. The result sits in an output register;
// the next input is accepted while it waits, and a stalled receiver holds the
// following result in the controller until the register frees up. Reset
// empties the queue at once; the memory contents need no clearing.
module sorted_event_queue #(
    parameter int QUEUE_DEPTH  = sevq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int KEY_BITS     = sevq_pkg::DEFAULT_KEY_BITS,
    parameter int PAYLOAD_BITS = sevq_pkg::DEFAULT_PAYLOAD_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               opcode,
    input  logic [KEY_BITS-1:0]                key_time,
    input  logic [PAYLOAD_BITS-1:0]            entry_payload,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         status,
    output logic                               popped_valid,
    output logic [KEY_BITS-1:0]                popped_time,
    output logic [PAYLOAD_BITS-1:0]            popped_payload,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   occupancy
);
    import sevq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    sevq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sevq_datapath #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .opcode         (opcode),
        .key_time       (key_time),
        .entry_payload  (entry_payload),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .popped_valid   (popped_valid),
        .popped_time    (popped_time),
        .popped_payload (popped_payload),
        .occupancy      (occupancy)
    );

endmodule

/* hw/rtl/sevq_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine of the sorted event queue.
// Depends on sevq_pkg; drives commands to sevq_datapath from its status.
module sevq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sevq_pkg::stat_t stat,
    output sevq_pkg::cmd_t  cmd
);
    import sevq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.rd_sel     = RD_IDX_M1;
        cmd.out_status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.is_pop)
                begin
                    if (stat.empty)
                    begin
                        state_next = S_RESP_EMPTY;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        state_next = S_POP_WAIT;
                    end
                end
                else if (stat.full)
                begin
                    state_next = S_RESP_FULL;
                end
                else if (stat.idx_zero)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_INS_WAIT;
                end
            end
            S_POP_WAIT:
            begin
                cmd.pop    = 1'b1;
                state_next = S_RESP_POP;
            end
            S_INS_WAIT:
            begin
                // Entries with a smaller key move up one slot; the new entry
                // lands just above the first entry whose key is not smaller.
                if (stat.prev_less)
                begin
                    cmd.shift = 1'b1;
                    if (stat.idx_one)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_IDX_M2;
                    end
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = S_RESP_INS;
                end
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = S_RESP_INS;
            end
            S_RESP_POP, S_RESP_INS, S_RESP_EMPTY, S_RESP_FULL:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_popped = (state_reg == S_RESP_POP);
                    if (state_reg == S_RESP_EMPTY)
                    begin
                        cmd.out_status = ST_EMPTY;
                    end
                    else if (state_reg == S_RESP_FULL)
                    begin
                        cmd.out_status = ST_FULL;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/sevq_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the sorted event queue: entry memory, count, slot index and
// result register. Depends on sevq_pkg; commanded by sevq_ctrl.
module sevq_datapath #(
    parameter int QUEUE_DEPTH  = sevq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int KEY_BITS     = sevq_pkg::DEFAULT_KEY_BITS,
    parameter int PAYLOAD_BITS = sevq_pkg::DEFAULT_PAYLOAD_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sevq_pkg::cmd_t                     cmd,
    output sevq_pkg::stat_t                    stat,
    input  logic                               opcode,
    input  logic [KEY_BITS-1:0]                key_time,
    input  logic [PAYLOAD_BITS-1:0]            entry_payload,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         status,
    output logic                               popped_valid,
    output logic [KEY_BITS-1:0]                popped_time,
    output logic [PAYLOAD_BITS-1:0]            popped_payload,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   occupancy
);
    import sevq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = KEY_BITS + PAYLOAD_BITS;

    // The memory holds entries in descending key order, so the smallest key
    // sits at slot count-1 and a pop needs no shifting.
    logic [EW-1:0] mem [QUEUE_DEPTH];

    logic                    op_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [EW-1:0]           rd_data_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [CW-1:0]           idx_reg;
    logic [CW-1:0]           idx_next;
    logic                    out_valid_reg;
    status_t                 status_reg;
    logic                    popped_valid_reg;
    logic [KEY_BITS-1:0]     popped_time_reg;
    logic [PAYLOAD_BITS-1:0] popped_payload_reg;
    logic [CW-1:0]           occupancy_reg;

    logic [CW-1:0] idx_m1;
    logic [CW-1:0] idx_m2;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic          wr_en;

    assign idx_m1  = idx_reg - CW'(1);
    assign idx_m2  = idx_reg - CW'(2);
    assign rd_addr = (cmd.rd_sel == RD_IDX_M2) ? idx_m2[AW-1:0] : idx_m1[AW-1:0];
    assign wr_addr = idx_reg[AW-1:0];
    assign wr_en   = cmd.shift | cmd.place;
    assign wr_data = cmd.shift ? rd_data_reg : {key_reg, pay_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= opcode;
            key_reg <= key_time;
            pay_reg <= entry_payload;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        if (cmd.capture)
        begin
            idx_next = count_reg;
        end
        else if (cmd.shift)
        begin
            idx_next = idx_m1;
        end
        if (cmd.place)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            status_reg       <= cmd.out_status;
            popped_valid_reg <= cmd.out_popped;
            popped_time_reg  <= cmd.out_popped ? rd_data_reg[EW-1:PAYLOAD_BITS] : '0;
            popped_payload_reg <= cmd.out_popped ? rd_data_reg[PAYLOAD_BITS-1:0] : '0;
            occupancy_reg    <= count_reg;
        end
    end

    assign stat.is_pop    = (op_reg == OP_POP);
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == CW'(QUEUE_DEPTH));
    assign stat.idx_zero  = (idx_reg == '0);
    assign stat.idx_one   = (idx_reg == CW'(1));
    assign stat.prev_less = (rd_data_reg[EW-1:PAYLOAD_BITS] < key_reg);
    assign stat.out_busy  = out_valid_reg & ~out_ready;

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign popped_valid   = popped_valid_reg;
    assign popped_time    = popped_time_reg;
    assign popped_payload = popped_payload_reg;
    assign occupancy      = occupancy_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.place |-> !stat.full)
        else $error("entry written into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !stat.empty)
        else $error("pop from an empty queue reached the datapath");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift |-> (idx_reg != '0) && (idx_reg <= count_reg))
        else $error("shift with slot index out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid_reg && !out_ready))
        else $error("result register overwritten while still pending");

endmodule
